FILE: design/jmpg_pkg.sv
package jmpg_pkg;

  localparam int AXES     = 3;
  localparam int ACCUM_W  = 48;
  localparam int TGT_W    = 32;
  localparam int FRAC_SH  = ACCUM_W - TGT_W;
  localparam int AX_W     = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int STEP_W   = 16;
  localparam int THR_W    = 48;
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W    = 17;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int SUM_W    = PROD_W + 4;
  localparam int MAG_W    = ACCUM_W + 1;
  localparam int DIVD_W   = MAG_W + 4;
  localparam int DVSR_W   = 2 * STEP_W + 2;
  localparam int RECIP_SH = 17;

  localparam logic [MUL_W-1:0] RECIP3 = MUL_W'(43691);

  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(300);
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(42949673);

  localparam logic [TGT_W-1:0] OUT_MAX = {1'b0, {(TGT_W-1){1'b1}}};
  localparam logic [TGT_W-1:0] OUT_MIN = {1'b1, {(TGT_W-1){1'b0}}};

  localparam logic [AX_W-1:0] AX_LAST = AX_W'(AXES - 1);

  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(2);

  localparam logic CMD_TARGET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic MODE_TRAP   = 1'b0;
  localparam logic MODE_LINEAR = 1'b1;

endpackage

FILE: design/jmpg_div.sv
module jmpg_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [jmpg_pkg::DIVD_W-1:0]       dividend_i,
  input  logic [jmpg_pkg::DVSR_W-1:0]       divisor_i,
  output logic                              done_o,
  output logic [jmpg_pkg::DIVD_W-1:0]       quotient_o
);

  localparam int CNT_W = $clog2(jmpg_pkg::DIVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(jmpg_pkg::DIVD_W - 1);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [jmpg_pkg::DVSR_W-1:0]   rem_q;
  logic [jmpg_pkg::DVSR_W-1:0]   rem_d;
  logic [jmpg_pkg::DVSR_W-1:0]   dvsr_q;
  logic [jmpg_pkg::DIVD_W-1:0]   quo_q;
  logic [jmpg_pkg::DIVD_W-1:0]   quo_d;
  logic [jmpg_pkg::DVSR_W:0]     rem_sh;
  logic [jmpg_pkg::DVSR_W:0]     diff;
  logic                          ge;

  // one restoring step per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[jmpg_pkg::DIVD_W-1]};
    diff   = rem_sh - {1'b0, dvsr_q};
    ge     = ~diff[jmpg_pkg::DVSR_W];
    rem_d  = ge ? diff[jmpg_pkg::DVSR_W-1:0] : rem_sh[jmpg_pkg::DVSR_W-1:0];
    quo_d  = {quo_q[jmpg_pkg::DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dvsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: design/joint_motion_profile_generator_unit.sv
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   command_i, target_0_i .. target_2_i
// out       output     out_valid_o / out_stall_i position_0_o .. position_2_o, moving_o
// cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// one word at a time; in_stall_o is high from acceptance until the result is registered
// target word: squared distance summed over the axes, then a 53-step serial divide per axis when a move starts
// tick word: a velocity and position step per axis while running, no result when idle
// the output register holds a stalled result while the next word is taken
// reset clears positions, rates and run state and loads register defaults
module joint_motion_profile_generator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic signed [jmpg_pkg::TGT_W-1:0]   target_0_i,
  input  logic signed [jmpg_pkg::TGT_W-1:0]   target_1_i,
  input  logic signed [jmpg_pkg::TGT_W-1:0]   target_2_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [jmpg_pkg::TGT_W-1:0]   position_0_o,
  output logic signed [jmpg_pkg::TGT_W-1:0]   position_1_o,
  output logic signed [jmpg_pkg::TGT_W-1:0]   position_2_o,
  output logic                                moving_o,
  input  logic                                cfg_we_i,
  input  logic [jmpg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [jmpg_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_SUM  = 4'd2;
  localparam logic [3:0] S_NN   = 4'd3;
  localparam logic [3:0] S_CMP  = 4'd4;
  localparam logic [3:0] S_DSET = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_TB1  = 4'd7;
  localparam logic [3:0] S_TB2  = 4'd8;
  localparam logic [3:0] S_TB3  = 4'd9;
  localparam logic [3:0] S_TVEL = 4'd10;
  localparam logic [3:0] S_TPOS = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam int AW = jmpg_pkg::ACCUM_W;
  localparam int TW = jmpg_pkg::TGT_W;

  logic [3:0]                      state_q;
  logic [jmpg_pkg::AX_W-1:0]       ax_q;
  logic [AW-1:0]                   pos_q  [jmpg_pkg::AXES];
  logic [AW-1:0]                   vel_q  [jmpg_pkg::AXES];
  logic [AW-1:0]                   acc_q  [jmpg_pkg::AXES];
  logic [TW-1:0]                   last_q [jmpg_pkg::AXES];
  logic [TW-1:0]                   tgt_q  [jmpg_pkg::AXES];
  logic [TW-1:0]                   tgt_in [jmpg_pkg::AXES];
  logic [TW-1:0]                   res_q  [jmpg_pkg::AXES];
  logic [TW-1:0]                   out_q  [jmpg_pkg::AXES];
  logic [jmpg_pkg::IDX_W-1:0]      idx_q;
  logic                            initialized_q;
  logic                            running_q;
  logic                            moving_q;
  logic                            out_valid_q;
  logic [jmpg_pkg::STEP_W-1:0]     step_q;
  logic                            mode_q;
  logic [jmpg_pkg::THR_W-1:0]      thr_q;
  logic [jmpg_pkg::PROD_W-1:0]     prod_q;
  logic [jmpg_pkg::SUM_W-1:0]      sum_q;
  logic [jmpg_pkg::STEP_W-1:0]     b1_q;
  logic [jmpg_pkg::STEP_W-1:0]     b2_q;
  logic [jmpg_pkg::DVSR_W-1:0]     dvsr_q;
  logic                            neg_q;

  logic                            in_acc;
  logic                            out_load;
  logic [jmpg_pkg::STEP_W-1:0]     nd;
  logic [TW:0]                     tgt_diff;
  logic [TW:0]                     tgt_diff_abs;
  logic [jmpg_pkg::MUL_W-1:0]      mul_a;
  logic [jmpg_pkg::MUL_W-1:0]      mul_b;
  logic [jmpg_pkg::PROD_W-1:0]     mul_p;
  logic [AW-1:0]                   tgt_acc;
  logic [AW:0]                     gap;
  logic                            gap_neg;
  logic [jmpg_pkg::MAG_W-1:0]      gap_mag;
  logic [jmpg_pkg::DIVD_W-1:0]     dividend;
  logic                            div_start;
  logic                            div_done;
  logic [jmpg_pkg::DIVD_W-1:0]     div_quot;
  logic [AW-1:0]                   rate;
  logic [AW-1:0]                   vel_new;
  logic [TW:0]                     rnd;
  logic [TW-1:0]                   rnd_sat;
  logic [jmpg_pkg::IDX_W-1:0]      n_ext;

  assign tgt_in[0] = target_0_i;
  assign tgt_in[1] = target_1_i;
  assign tgt_in[2] = target_2_i;

  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign nd         = (step_q == '0) ? jmpg_pkg::STEP_W'(1) : step_q;
  assign n_ext      = jmpg_pkg::IDX_W'(step_q);

  // squared distance operand
  always_comb begin
    tgt_diff     = {tgt_q[ax_q][TW-1], tgt_q[ax_q]} - {last_q[ax_q][TW-1], last_q[ax_q]};
    tgt_diff_abs = tgt_diff[TW] ? -tgt_diff : tgt_diff;
  end

  // shared multiplier
  always_comb begin
    case (state_q)
      S_SQ: begin
        mul_a = tgt_diff_abs[TW-1:0];
        mul_b = tgt_diff_abs[TW-1:0];
      end
      S_NN: begin
        mul_a = jmpg_pkg::MUL_W'(nd);
        mul_b = jmpg_pkg::MUL_W'(nd);
      end
      S_TB1: begin
        mul_a = jmpg_pkg::MUL_W'(step_q);
        mul_b = jmpg_pkg::RECIP3;
      end
      S_TB2: begin
        mul_a = jmpg_pkg::MUL_W'({step_q, 1'b0});
        mul_b = jmpg_pkg::RECIP3;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // distance from current position to new target
  always_comb begin
    tgt_acc  = {tgt_q[ax_q], {jmpg_pkg::FRAC_SH{1'b0}}};
    gap      = {tgt_acc[AW-1], tgt_acc} - {pos_q[ax_q][AW-1], pos_q[ax_q]};
    gap_neg  = gap[AW];
    gap_mag  = gap_neg ? -gap : gap;
    if (mode_q == jmpg_pkg::MODE_LINEAR) begin
      dividend = jmpg_pkg::DIVD_W'(gap_mag);
    end else begin
      dividend = jmpg_pkg::DIVD_W'({gap_mag, 3'b000}) + jmpg_pkg::DIVD_W'(gap_mag);
    end
  end

  assign div_start = (state_q == S_DSET);
  assign rate      = neg_q ? -div_quot[AW-1:0] : div_quot[AW-1:0];

  jmpg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (dvsr_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // phase step on velocity
  always_comb begin
    vel_new = vel_q[ax_q];
    if (mode_q == jmpg_pkg::MODE_TRAP) begin
      if (idx_q < jmpg_pkg::IDX_W'(b1_q)) begin
        vel_new = vel_q[ax_q] + acc_q[ax_q];
      end else if (idx_q < jmpg_pkg::IDX_W'(b2_q)) begin
        vel_new = vel_q[ax_q];
      end else if (idx_q < n_ext) begin
        vel_new = vel_q[ax_q] - acc_q[ax_q];
      end
    end
  end

  // round half up and saturate
  always_comb begin
    rnd = {pos_q[ax_q][AW-1], pos_q[ax_q][AW-1:jmpg_pkg::FRAC_SH]}
        + (TW+1)'(pos_q[ax_q][jmpg_pkg::FRAC_SH-1]);
    if (rnd[TW] != rnd[TW-1]) begin
      rnd_sat = rnd[TW] ? jmpg_pkg::OUT_MIN : jmpg_pkg::OUT_MAX;
    end else begin
      rnd_sat = rnd[TW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ax_q          <= '0;
      idx_q         <= '0;
      initialized_q <= 1'b0;
      running_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      step_q        <= jmpg_pkg::STEP_RST;
      mode_q        <= jmpg_pkg::MODE_TRAP;
      thr_q         <= jmpg_pkg::THR_RST;
      for (int i = 0; i < jmpg_pkg::AXES; i++) begin
        pos_q[i]  <= '0;
        vel_q[i]  <= '0;
        acc_q[i]  <= '0;
        last_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          jmpg_pkg::REG_STEP_COUNT: step_q <= cfg_data_i[jmpg_pkg::STEP_W-1:0];
          jmpg_pkg::REG_MODE:       mode_q <= cfg_data_i[0];
          jmpg_pkg::REG_THRESHOLD:  thr_q  <= cfg_data_i[jmpg_pkg::THR_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            ax_q <= '0;
            if (command_i == jmpg_pkg::CMD_TARGET) begin
              state_q <= S_SQ;
              if (!initialized_q) begin
                for (int i = 0; i < jmpg_pkg::AXES; i++) begin
                  pos_q[i]  <= {tgt_in[i], {jmpg_pkg::FRAC_SH{1'b0}}};
                  last_q[i] <= tgt_in[i];
                end
                idx_q         <= '0;
                initialized_q <= 1'b1;
              end
            end else if (running_q) begin
              idx_q   <= idx_q + jmpg_pkg::IDX_W'(1);
              state_q <= S_TB1;
            end
          end
        end
        S_SQ: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (ax_q == jmpg_pkg::AX_LAST) begin
            state_q <= S_NN;
          end else begin
            ax_q    <= ax_q + jmpg_pkg::AX_W'(1);
            state_q <= S_SQ;
          end
        end
        S_NN: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          ax_q <= '0;
          if (sum_q > jmpg_pkg::SUM_W'(thr_q)) begin
            running_q <= 1'b1;
            idx_q     <= '0;
            for (int i = 0; i < jmpg_pkg::AXES; i++) begin
              last_q[i] <= tgt_q[i];
            end
            state_q <= S_DSET;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_DSET: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (mode_q == jmpg_pkg::MODE_LINEAR) begin
              vel_q[ax_q] <= rate;
            end else begin
              vel_q[ax_q] <= '0;
              acc_q[ax_q] <= rate;
            end
            if (ax_q == jmpg_pkg::AX_LAST) begin
              ax_q    <= '0;
              state_q <= S_EMIT;
            end else begin
              ax_q    <= ax_q + jmpg_pkg::AX_W'(1);
              state_q <= S_DSET;
            end
          end
        end
        S_TB1: begin
          state_q <= S_TB2;
        end
        S_TB2: begin
          state_q <= S_TB3;
        end
        S_TB3: begin
          if (idx_q > n_ext) begin
            running_q <= 1'b0;
          end
          ax_q    <= '0;
          state_q <= S_TVEL;
        end
        S_TVEL: begin
          vel_q[ax_q] <= vel_new;
          state_q     <= S_TPOS;
        end
        S_TPOS: begin
          if (idx_q < n_ext) begin
            pos_q[ax_q] <= pos_q[ax_q] + vel_q[ax_q];
          end
          if (ax_q == jmpg_pkg::AX_LAST) begin
            ax_q    <= '0;
            state_q <= S_EMIT;
          end else begin
            ax_q    <= ax_q + jmpg_pkg::AX_W'(1);
            state_q <= S_TVEL;
          end
        end
        S_EMIT: begin
          if (ax_q == jmpg_pkg::AX_LAST) begin
            ax_q    <= '0;
            state_q <= S_OUT;
          end else begin
            ax_q <= ax_q + jmpg_pkg::AX_W'(1);
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_acc) begin
      for (int i = 0; i < jmpg_pkg::AXES; i++) begin
        tgt_q[i] <= tgt_in[i];
      end
      sum_q <= '0;
    end
    if (state_q == S_SUM) begin
      sum_q <= sum_q + jmpg_pkg::SUM_W'(prod_q);
    end
    if (state_q == S_CMP) begin
      if (mode_q == jmpg_pkg::MODE_LINEAR) begin
        dvsr_q <= jmpg_pkg::DVSR_W'(nd);
      end else begin
        dvsr_q <= jmpg_pkg::DVSR_W'({prod_q[2*jmpg_pkg::STEP_W-1:0], 1'b0});
      end
    end
    if (state_q == S_DSET) begin
      neg_q <= gap_neg;
    end
    if (state_q == S_TB2) begin
      b1_q <= prod_q[jmpg_pkg::RECIP_SH +: jmpg_pkg::STEP_W];
    end
    if (state_q == S_TB3) begin
      b2_q <= prod_q[jmpg_pkg::RECIP_SH +: jmpg_pkg::STEP_W];
    end
    if (state_q == S_EMIT) begin
      res_q[ax_q] <= rnd_sat;
    end
    if (out_load) begin
      for (int i = 0; i < jmpg_pkg::AXES; i++) begin
        out_q[i] <= res_q[i];
      end
      moving_q <= running_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign position_0_o = out_q[0];
  assign position_1_o = out_q[1];
  assign position_2_o = out_q[2];
  assign moving_o     = moving_q;

endmodule

FILE: tb/tb_joint_motion_profile_generator_unit.sv
module tb_joint_motion_profile_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import jmpg_pkg::*;

  localparam int  SETTLE_CYCLES = 20;
  localparam int  END_HOLD      = 300;
  localparam int  CYCLE_LIMIT   = 2000000;
  localparam longint POS_HI     = 64'sd2147483647;
  localparam longint POS_LO     = -64'sd2147483648;

  typedef struct packed {
    logic [TGT_W-1:0] pos0;
    logic [TGT_W-1:0] pos1;
    logic [TGT_W-1:0] pos2;
    logic             moving;
  } joint_pose_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    command_i = CMD_TARGET;
  logic signed [TGT_W-1:0] target_0_i = '0;
  logic signed [TGT_W-1:0] target_1_i = '0;
  logic signed [TGT_W-1:0] target_2_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [TGT_W-1:0] position_0_o;
  logic signed [TGT_W-1:0] position_1_o;
  logic signed [TGT_W-1:0] position_2_o;
  logic                    moving_o;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_W-1:0]        cfg_data_i = '0;

  joint_motion_profile_generator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .target_0_i   (target_0_i),
    .target_1_i   (target_1_i),
    .target_2_i   (target_2_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .position_0_o (position_0_o),
    .position_1_o (position_1_o),
    .position_2_o (position_2_o),
    .moving_o     (moving_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // profile state mirrored from the block
  bit [STEP_W-1:0]         cfg_steps = STEP_RST;
  bit                      cfg_mode  = MODE_TRAP;
  bit [THR_W-1:0]          cfg_thr   = THR_RST;
  bit [ACCUM_W-1:0]        pos_acc  [AXES];
  bit [ACCUM_W-1:0]        vel      [AXES];
  bit [ACCUM_W-1:0]        accel    [AXES];
  bit signed [TGT_W-1:0]   last_tgt [AXES];
  bit [IDX_W-1:0]          step_idx;
  bit                      homed;
  bit                      in_motion;

  joint_pose_t pending_poses [$];
  int          poses_predicted = 0;
  int          words_sent = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          sender_idle_pct = 13;
  int          rx_stall_pct = 65;

  function automatic bit [TGT_W-1:0] rounded_pos(bit [ACCUM_W-1:0] a);
    longint q;
    q = $signed(a);
    q = q >>> FRAC_SH;
    q += a[FRAC_SH-1];
    if (q > POS_HI) q = POS_HI;
    else if (q < POS_LO) q = POS_LO;
    return q[TGT_W-1:0];
  endfunction

  function automatic bit [ACCUM_W-1:0] scaled_rate(bit [63:0] mag, bit neg, bit [63:0] dvsr,
                                                   bit [63:0] mul);
    bit [63:0] q, r, res;
    q = mag / dvsr;
    r = mag % dvsr;
    res = q * mul + (r * mul) / dvsr;
    if (neg) res = 64'd0 - res;
    return res[ACCUM_W-1:0];
  endfunction

  function automatic void push_pose();
    joint_pose_t p;
    p.pos0   = rounded_pos(pos_acc[0]);
    p.pos1   = rounded_pos(pos_acc[1]);
    p.pos2   = rounded_pos(pos_acc[2]);
    p.moving = in_motion;
    pending_poses.push_back(p);
    poses_predicted++;
  endfunction

  function automatic void profile_take_target(bit [TGT_W-1:0] t0, bit [TGT_W-1:0] t1,
                                              bit [TGT_W-1:0] t2);
    bit signed [TGT_W-1:0] t [AXES];
    bit [63:0] dist_sq, sq, mag, nd;
    longint    d, a, b;
    bit        neg;
    t[0] = t0;
    t[1] = t1;
    t[2] = t2;
    nd = (cfg_steps == 0) ? 64'd1 : 64'(cfg_steps);
    if (!homed) begin
      for (int i = 0; i < AXES; i++) begin
        pos_acc[i]  = {t[i], {FRAC_SH{1'b0}}};
        last_tgt[i] = t[i];
      end
      step_idx = '0;
      homed = 1'b1;
    end
    dist_sq = '0;
    for (int i = 0; i < AXES; i++) begin
      d = longint'(t[i]) - longint'(last_tgt[i]);
      mag = (d < 0) ? -d : d;
      sq = mag * mag;
      dist_sq = (dist_sq > ~64'd0 - sq) ? ~64'd0 : dist_sq + sq;
    end
    if (dist_sq > 64'(cfg_thr)) begin
      for (int i = 0; i < AXES; i++) begin
        a = $signed({t[i], {FRAC_SH{1'b0}}});
        b = $signed(pos_acc[i]);
        neg = a < b;
        mag = neg ? b - a : a - b;
        if (cfg_mode == MODE_LINEAR) begin
          vel[i] = scaled_rate(mag, neg, nd, 64'd1);
        end else begin
          vel[i] = '0;
          accel[i] = scaled_rate(mag, neg, 2 * nd * nd, 64'd9);
        end
        last_tgt[i] = t[i];
      end
      step_idx = '0;
      in_motion = 1'b1;
    end
    push_pose();
  endfunction

  function automatic void profile_take_tick();
    int unsigned nn, b1, b2;
    if (!in_motion) return;
    nn = cfg_steps;
    b1 = nn / 3;
    b2 = (nn * 2) / 3;
    step_idx = step_idx + 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (cfg_mode == MODE_LINEAR) begin
        if (step_idx < nn) pos_acc[i] = pos_acc[i] + vel[i];
      end else if (step_idx < b1) begin
        vel[i] = vel[i] + accel[i];
        pos_acc[i] = pos_acc[i] + vel[i];
      end else if (step_idx < b2) begin
        pos_acc[i] = pos_acc[i] + vel[i];
      end else if (step_idx < nn) begin
        vel[i] = vel[i] - accel[i];
        pos_acc[i] = pos_acc[i] + vel[i];
      end
    end
    if (step_idx > nn) in_motion = 1'b0;
    push_pose();
  endfunction

  // result checking
  task automatic check_field(string name, logic [TGT_W-1:0] exp_v, logic [TGT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_poses.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h %h %h %b", $time,
                 position_0_o, position_1_o, position_2_o, moving_o);
        mismatches++;
      end else begin
        check_field("position_0", pending_poses[0].pos0, position_0_o);
        check_field("position_1", pending_poses[0].pos1, position_1_o);
        check_field("position_2", pending_poses[0].pos2, position_2_o);
        check_field("moving", TGT_W'(pending_poses[0].moving), TGT_W'(moving_o));
        void'(pending_poses.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus helpers
  task automatic send_word(bit cmd, bit [TGT_W-1:0] t0, bit [TGT_W-1:0] t1,
                           bit [TGT_W-1:0] t2);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    target_0_i <= t0;
    target_1_i <= t1;
    target_2_i <= t2;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    if (cmd == CMD_TARGET) profile_take_target(t0, t1, t2);
    else profile_take_tick();
  endtask

  task automatic send_tick();
    send_word(CMD_TICK, $urandom(), $urandom(), $urandom());
  endtask

  task automatic settle_block(int hold);
    in_valid_i <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (hold) @(posedge clk_i);
  endtask

  // unused upper data bits carry junk
  task automatic program_regs(bit [STEP_W-1:0] steps, bit mode, bit [THR_W-1:0] thr);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_STEP_COUNT;
    cfg_data_i  <= (CFG_W'($urandom()) << STEP_W) | CFG_W'(steps);
    @(posedge clk_i);
    cfg_index_i <= REG_MODE;
    cfg_data_i  <= (CFG_W'($urandom()) << 1) | CFG_W'(mode);
    @(posedge clk_i);
    cfg_index_i <= REG_THRESHOLD;
    cfg_data_i  <= CFG_W'(thr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_steps = steps;
    cfg_mode  = mode;
    cfg_thr   = thr;
  endtask

  function automatic bit [STEP_W-1:0] pick_steps();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return STEP_W'($urandom_range(0, 12));
    else if (r < 90) return STEP_W'($urandom_range(13, 64));
    else if (r < 98) return STEP_W'($urandom_range(65, 65535));
    return '1;
  endfunction

  function automatic bit [THR_W-1:0] pick_threshold();
    case ($urandom_range(9))
      0:         return '0;
      1:         return '1;
      2:         return THR_RST;
      3, 4, 5, 6: return THR_W'($urandom_range(0, 1 << 27));
      default:   return THR_W'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic bit [TGT_W-1:0] pick_coord();
    if ($urandom_range(1)) return $urandom();
    return TGT_W'($urandom_range(0, 1 << 22)) - TGT_W'(1 << 21);
  endfunction

  function automatic bit [TGT_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return OUT_MIN;
      1:       return OUT_MAX;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic bit [TGT_W-1:0] near_coord(int i);
    return last_tgt[i] + TGT_W'($urandom_range(0, 16000)) - TGT_W'(8000);
  endfunction

  // tests
  task automatic test_first_target_and_threshold();
    send_tick();
    send_word(CMD_TARGET, 32'h0001_0000, 32'hFFFE_8000, 32'h7FFF_8000);
    send_word(CMD_TARGET, last_tgt[0] + 1, last_tgt[1], last_tgt[2]);
    send_word(CMD_TARGET, last_tgt[0] + 32'h0010_0000, last_tgt[1] - 32'h0010_0000,
              last_tgt[2] - 32'h0020_0000);
    repeat (2) send_tick();
    settle_block(SETTLE_CYCLES);
    program_regs(16'd3, MODE_TRAP, 48'd10000);
    // distance exactly at threshold, then one past it
    send_word(CMD_TARGET, last_tgt[0] + 100, last_tgt[1], last_tgt[2]);
    send_word(CMD_TARGET, last_tgt[0] + 101, last_tgt[1], last_tgt[2]);
    repeat (5) send_tick();
  endtask

  task automatic test_config_extremes();
    settle_block(SETTLE_CYCLES);
    program_regs(16'd3, MODE_LINEAR, '0);
    send_word(CMD_TARGET, OUT_MAX, OUT_MIN, '1);
    repeat (4) send_tick();
    send_word(CMD_TARGET, last_tgt[0], last_tgt[1], last_tgt[2]);
    settle_block(SETTLE_CYCLES);
    program_regs(16'd0, MODE_LINEAR, '1);
    send_word(CMD_TARGET, OUT_MIN, OUT_MAX, '0);
    repeat (2) send_tick();
    settle_block(SETTLE_CYCLES);
    program_regs(16'd1, MODE_TRAP, '0);
    send_word(CMD_TARGET, OUT_MAX, OUT_MIN, 32'h0000_8000);
    repeat (2) send_tick();
    settle_block(SETTLE_CYCLES);
    program_regs('1, MODE_LINEAR, '0);
    send_word(CMD_TARGET, '0, '0, '0);
    send_tick();
  endtask

  task automatic test_random_profiles(int idle_pct, int stall_pct, int budget);
    int start_count, batch_end, ticks, kind;
    sender_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    start_count = words_sent;
    while (words_sent - start_count < budget) begin
      settle_block(SETTLE_CYCLES);
      program_regs(pick_steps(), 1'($urandom_range(1)), pick_threshold());
      batch_end = words_sent + $urandom_range(10, 50);
      while (words_sent < batch_end) begin
        kind = $urandom_range(99);
        if (kind < 70) begin
          send_word(CMD_TARGET, pick_coord(), pick_coord(), pick_coord());
          ticks = (cfg_steps <= 40) ? cfg_steps + 1 + $urandom_range(2) : $urandom_range(1, 30);
          repeat (ticks) send_tick();
        end else if (kind < 85) begin
          send_word(CMD_TARGET, near_coord(0), near_coord(1), near_coord(2));
        end else if (kind < 95) begin
          repeat ($urandom_range(1, 3)) send_tick();
        end else begin
          send_word(CMD_TARGET, pick_extreme(), pick_extreme(), pick_extreme());
          repeat ($urandom_range(0, 4)) send_tick();
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_target_and_threshold();
    test_config_extremes();
    test_random_profiles(13, 65, 425);
    test_random_profiles(65, 13, 425);
    test_random_profiles(0, 0, 425);
    settle_block(END_HOLD);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
